### hdl/pot_to_midi_cc_smoother_defines.svh
// assertion macros shared by the smoother rtl
`ifndef POT_TO_MIDI_CC_SMOOTHER_DEFINES_SVH
`define POT_TO_MIDI_CC_SMOOTHER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PMCS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PMCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/pmcs_pkg.sv
package pmcs_pkg;

   localparam int WINDOW_BITS    = 10;
   localparam int THRESH_BITS    = 8;
   localparam int CC_BITS        = 7;
   localparam int CHANNEL_BITS   = 5;
   localparam int ACC_BITS       = 9;
   localparam int CFG_INDEX_BITS = 3;
   localparam int CFG_DATA_BITS  = 10;
   localparam int DIVIDEND_BITS  = WINDOW_BITS + CC_BITS;
   localparam int DIV_COUNT_BITS = 5;

   localparam logic [CC_BITS-1:0] CC_MAX = 7'd127;
   localparam logic [CC_BITS-1:0] CC_OFF = 7'd0;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_THRESHOLD = 3'd0,
      REG_IN_LOW    = 3'd1,
      REG_IN_HIGH   = 3'd2,
      REG_OUT_LOW   = 3'd3,
      REG_OUT_HIGH  = 3'd4,
      REG_CONTROL   = 3'd5,
      REG_KILL      = 3'd6,
      REG_CHANNEL   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]  smoothing_threshold;
      logic [WINDOW_BITS-1:0]  in_low;
      logic [WINDOW_BITS-1:0]  in_high;
      logic [CC_BITS-1:0]      out_low;
      logic [CC_BITS-1:0]      out_high;
      logic [CC_BITS-1:0]      control_number;
      logic [CC_BITS-1:0]      kill_number;
      logic [CHANNEL_BITS-1:0] midi_channel;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_FILTER = 9'b000000010,
      S_CLAMP  = 9'b000000100,
      S_MUL    = 9'b000001000,
      S_DIV    = 9'b000010000,
      S_DECIDE = 9'b000100000,
      S_PRE    = 9'b001000000,
      S_MAIN   = 9'b010000000,
      S_POST   = 9'b100000000
   } state_type;

endpackage

### hdl/pmcs_channels.sv
interface pmcs_req_if #(parameter int SAMPLE_BITS = 10) ();
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface pmcs_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [pmcs_pkg::CC_BITS-1:0]      controller;
   logic [pmcs_pkg::CC_BITS-1:0]      level;
   logic [pmcs_pkg::CHANNEL_BITS-1:0] channel;
   logic                             last;

   modport source (output valid, output controller, output level, output channel,
                   output last, input ready);
   modport sink (input valid, input controller, input level, input channel,
                 input last, output ready);
endinterface

### hdl/pmcs_cfg_regs.sv
module pmcs_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pmcs_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [pmcs_pkg::CFG_DATA_BITS-1:0]  csr_wdata,
   output pmcs_pkg::cfg_type                   cfg
);

   pmcs_pkg::cfg_type cfg_ff;
   pmcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pmcs_pkg::reg_index_type'(csr_index))
            pmcs_pkg::REG_THRESHOLD:
               cfg_in.smoothing_threshold = csr_wdata[pmcs_pkg::THRESH_BITS-1:0];
            pmcs_pkg::REG_IN_LOW:   cfg_in.in_low  = csr_wdata[pmcs_pkg::WINDOW_BITS-1:0];
            pmcs_pkg::REG_IN_HIGH:  cfg_in.in_high = csr_wdata[pmcs_pkg::WINDOW_BITS-1:0];
            pmcs_pkg::REG_OUT_LOW:  cfg_in.out_low  = csr_wdata[pmcs_pkg::CC_BITS-1:0];
            pmcs_pkg::REG_OUT_HIGH: cfg_in.out_high = csr_wdata[pmcs_pkg::CC_BITS-1:0];
            pmcs_pkg::REG_CONTROL:
               cfg_in.control_number = csr_wdata[pmcs_pkg::CC_BITS-1:0];
            pmcs_pkg::REG_KILL:     cfg_in.kill_number = csr_wdata[pmcs_pkg::CC_BITS-1:0];
            pmcs_pkg::REG_CHANNEL:
               cfg_in.midi_channel = csr_wdata[pmcs_pkg::CHANNEL_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_threshold <= 8'd4;
         cfg_ff.in_low              <= 10'd0;
         cfg_ff.in_high             <= 10'd1023;
         cfg_ff.out_low             <= 7'd0;
         cfg_ff.out_high            <= 7'd127;
         cfg_ff.control_number      <= 7'd0;
         cfg_ff.kill_number         <= 7'd0;
         cfg_ff.midi_channel        <= 5'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/pmcs_divider.sv
module pmcs_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pmcs_pkg::DIVIDEND_BITS-1:0] dividend,
   input  logic [pmcs_pkg::WINDOW_BITS-1:0]   divisor,
   output pmcs_pkg::div_sts_type              sts,
   output logic [pmcs_pkg::DIVIDEND_BITS-1:0] quotient
);

   localparam int QB = pmcs_pkg::DIVIDEND_BITS;
   localparam int RB = pmcs_pkg::WINDOW_BITS;
   localparam int CB = pmcs_pkg::DIV_COUNT_BITS;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CB-1:0] count_ff, count_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [RB-1:0] rem_ff, rem_in;
   logic [RB:0]   trial;
   logic [RB:0]   trial_diff;

   // one restoring step per cycle, dividend shifts out as quotient shifts in
   always_comb begin
      trial      = {rem_ff, quo_ff[QB-1]};
      trial_diff = trial - {1'b0, divisor};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CB'(QB);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_diff[RB-1:0];
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[RB-1:0];
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         count_in = count_ff - CB'(1);
         if (count_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/pot_to_midi_cc_smoother.sv
// Potentiometer smoother and MIDI control-change generator. Takes one sample
// at a time: ready is high only while the sequencer is idle. A sample runs
// through filter, window clamp, one multiply and a 17-step serial restoring
// divider, then emits zero, one or two messages (kill-on before or kill-off
// after the main message) through an output register, so the next sample can
// be taken while the last message still waits. The divider gives one quotient
// bit per cycle; an empty or reversed input window skips the divider.

`include "pot_to_midi_cc_smoother_defines.svh"

module pot_to_midi_cc_smoother #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   pmcs_req_if.sink                            req_chan,
   pmcs_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [pmcs_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [pmcs_pkg::CFG_DATA_BITS-1:0]  csr_wdata
);

   localparam int WB       = pmcs_pkg::WINDOW_BITS;
   localparam int CCB      = pmcs_pkg::CC_BITS;
   localparam int AB       = pmcs_pkg::ACC_BITS;
   localparam int SUM_BITS = SAMPLE_BITS + 2;
   localparam int CMP_BITS = (SAMPLE_BITS > WB) ? SAMPLE_BITS : WB;

   pmcs_pkg::cfg_type     cfg;
   pmcs_pkg::div_sts_type div_sts;
   pmcs_pkg::state_type   state_ff, state_in;

   logic                                  cmd_ff, cmd_in;
   logic [SAMPLE_BITS-1:0]                sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]                level_ff, level_in;
   logic signed [AB-1:0]                  acc_ff, acc_in;
   logic [CCB-1:0]                        last_sent_ff, last_sent_in;
   logic [WB-1:0]                         xoff_ff, xoff_in;
   logic [WB-1:0]                         den_ff, den_in;
   logic [CCB-1:0]                        span_mag_ff, span_mag_in;
   logic                                  span_neg_ff, span_neg_in;
   logic [CCB-1:0]                        mapped_ff, mapped_in;
   logic                                  kill_off_ff, kill_off_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [CCB-1:0]                        rsp_ctl_ff, rsp_ctl_in;
   logic [CCB-1:0]                        rsp_lvl_ff, rsp_lvl_in;
   logic [pmcs_pkg::CHANNEL_BITS-1:0]     rsp_chn_ff;
   logic                                  rsp_last_ff, rsp_last_in;
   logic                                  out_free;
   logic                                  out_load;

   logic                                  div_start;
   logic [pmcs_pkg::DIVIDEND_BITS-1:0]    div_dividend;
   logic [pmcs_pkg::DIVIDEND_BITS-1:0]    div_quotient;
   logic [CCB-1:0]                        quo_cc;

   logic signed [SUM_BITS-1:0]            acc_ext, diff, acc_half, acc_next, acc_abs;
   logic signed [SUM_BITS-1:0]            thr_ext;
   logic [CMP_BITS-1:0]                   x_ext, lo_ext, hi_ext;
   logic [WB-1:0]                         x_clamp;
   logic                                  kill_en;
   logic                                  kill_on;
   logic                                  kill_off;
   logic [AB-1:0]                         acc_mag;

   pmcs_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pmcs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   assign req_chan.ready = (state_ff == pmcs_pkg::S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign div_dividend   = pmcs_pkg::DIVIDEND_BITS'(xoff_ff)
                         * pmcs_pkg::DIVIDEND_BITS'(span_mag_ff);
   assign quo_cc         = div_quotient[CCB-1:0];
   assign kill_en        = (cfg.kill_number != '0);
   assign acc_mag        = acc_ff[AB-1] ? AB'(-acc_ff) : AB'(acc_ff);

   // leaky change accumulator
   always_comb begin
      acc_ext  = SUM_BITS'(acc_ff);
      thr_ext  = $signed(SUM_BITS'(cfg.smoothing_threshold));
      diff     = $signed({2'b00, sample_ff}) - $signed({2'b00, level_ff});
      acc_half = acc_ext + $signed({{(SUM_BITS-1){1'b0}}, acc_ff[AB-1]});
      if (sample_ff == '0) begin
         acc_next = -thr_ext;
      end else if (sample_ff == level_ff) begin
         acc_next = acc_half >>> 1;
      end else begin
         acc_next = acc_ext + diff;
      end
      acc_abs = acc_next[SUM_BITS-1] ? -acc_next : acc_next;
   end

   // window clamp
   always_comb begin
      x_ext  = CMP_BITS'(level_ff);
      lo_ext = CMP_BITS'(cfg.in_low);
      hi_ext = CMP_BITS'(cfg.in_high);
      if (x_ext < lo_ext) begin
         x_clamp = cfg.in_low;
      end else if (x_ext > hi_ext) begin
         x_clamp = cfg.in_high;
      end else begin
         x_clamp = x_ext[WB-1:0];
      end
   end

   assign kill_on  = !cmd_ff && kill_en && (last_sent_ff == cfg.out_low)
                   && (mapped_ff > cfg.out_low);
   assign kill_off = !cmd_ff && kill_en && (last_sent_ff >= cfg.out_low)
                   && (mapped_ff == cfg.out_low);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sample_in    = sample_ff;
      level_in     = level_ff;
      acc_in       = acc_ff;
      last_sent_in = last_sent_ff;
      xoff_in      = xoff_ff;
      den_in       = den_ff;
      span_mag_in  = span_mag_ff;
      span_neg_in  = span_neg_ff;
      mapped_in    = mapped_ff;
      kill_off_in  = kill_off_ff;
      div_start    = 1'b0;
      out_load     = 1'b0;
      rsp_ctl_in   = rsp_ctl_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         pmcs_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = req_chan.cmd;
               sample_in = req_chan.sample;
               state_in  = pmcs_pkg::S_FILTER;
            end
         end
         pmcs_pkg::S_FILTER: begin
            if (cmd_ff) begin
               level_in = sample_ff;
            end else if (acc_abs >= thr_ext) begin
               level_in = sample_ff;
               acc_in   = '0;
            end else begin
               acc_in = AB'(acc_next);
            end
            state_in = pmcs_pkg::S_CLAMP;
         end
         pmcs_pkg::S_CLAMP: begin
            if (cfg.in_high == cfg.in_low) begin
               mapped_in = cfg.out_low;
               state_in  = pmcs_pkg::S_DECIDE;
            end else if (cfg.in_low > cfg.in_high) begin
               // reversed window: only the ends remain
               mapped_in = (x_ext < lo_ext) ? cfg.out_low : cfg.out_high;
               state_in  = pmcs_pkg::S_DECIDE;
            end else begin
               xoff_in     = x_clamp - cfg.in_low;
               den_in      = cfg.in_high - cfg.in_low;
               span_neg_in = (cfg.out_low > cfg.out_high);
               span_mag_in = (cfg.out_low > cfg.out_high) ? cfg.out_low - cfg.out_high
                                                           : cfg.out_high - cfg.out_low;
               state_in    = pmcs_pkg::S_MUL;
            end
         end
         pmcs_pkg::S_MUL: begin
            div_start = 1'b1;
            state_in  = pmcs_pkg::S_DIV;
         end
         pmcs_pkg::S_DIV: begin
            if (div_sts.done) begin
               mapped_in = span_neg_ff ? cfg.out_low - quo_cc : cfg.out_low + quo_cc;
               state_in  = pmcs_pkg::S_DECIDE;
            end
         end
         pmcs_pkg::S_DECIDE: begin
            if (!cmd_ff && (mapped_ff == last_sent_ff)) begin
               state_in = pmcs_pkg::S_IDLE;
            end else begin
               kill_off_in  = kill_off;
               last_sent_in = mapped_ff;
               state_in     = kill_on ? pmcs_pkg::S_PRE : pmcs_pkg::S_MAIN;
            end
         end
         pmcs_pkg::S_PRE: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_ctl_in  = cfg.kill_number;
               rsp_lvl_in  = pmcs_pkg::CC_MAX;
               rsp_last_in = 1'b0;
               state_in    = pmcs_pkg::S_MAIN;
            end
         end
         pmcs_pkg::S_MAIN: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_ctl_in  = cfg.control_number;
               rsp_lvl_in  = mapped_ff;
               rsp_last_in = !kill_off_ff;
               state_in    = kill_off_ff ? pmcs_pkg::S_POST : pmcs_pkg::S_IDLE;
            end
         end
         pmcs_pkg::S_POST: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_ctl_in  = cfg.kill_number;
               rsp_lvl_in  = pmcs_pkg::CC_OFF;
               rsp_last_in = 1'b1;
               state_in    = pmcs_pkg::S_IDLE;
            end
         end
         default: state_in = pmcs_pkg::S_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmcs_pkg::S_IDLE;
         level_ff     <= '0;
         acc_ff       <= '0;
         last_sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         acc_ff       <= acc_in;
         last_sent_ff <= last_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sample_ff   <= sample_in;
      xoff_ff     <= xoff_in;
      den_ff      <= den_in;
      span_mag_ff <= span_mag_in;
      span_neg_ff <= span_neg_in;
      mapped_ff   <= mapped_in;
      kill_off_ff <= kill_off_in;
      rsp_ctl_ff  <= rsp_ctl_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_last_ff <= rsp_last_in;
      if (out_load) begin
         rsp_chn_ff <= cfg.midi_channel;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.controller = rsp_ctl_ff;
   assign rsp_chan.level      = rsp_lvl_ff;
   assign rsp_chan.channel    = rsp_chn_ff;
   assign rsp_chan.last       = rsp_last_ff;

   `PMCS_ASSERT_HOLDS(a_div_done_in_div, div_sts.done, state_ff == pmcs_pkg::S_DIV, "divider done outside divide state")
   `PMCS_ASSERT_NEXT(a_idle_holds, (state_ff == pmcs_pkg::S_IDLE) && !req_chan.valid, state_ff == pmcs_pkg::S_IDLE, "sequencer left idle without a transfer")
   `PMCS_ASSERT_NEXT(a_acc_below_thr, (state_ff == pmcs_pkg::S_FILTER) && !cmd_ff, (acc_mag < {1'b0, cfg.smoothing_threshold}) || (acc_ff == '0), "accumulator kept at or above threshold")
   `PMCS_ASSERT_HOLDS(a_mapped_in_range, state_ff == pmcs_pkg::S_DECIDE, ((mapped_ff >= cfg.out_low) && (mapped_ff <= cfg.out_high)) || ((mapped_ff <= cfg.out_low) && (mapped_ff >= cfg.out_high)), "mapped value outside output range")

endmodule

### bench/tb_top.sv
module tb_top;
   import pmcs_pkg::*;

   localparam int SAMPLE_BITS    = 10;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 75;

   typedef struct packed {
      logic [CC_BITS-1:0]      controller;
      logic [CC_BITS-1:0]      level;
      logic [CHANNEL_BITS-1:0] channel;
      logic                    last;
   } cc_msg_t;

   typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

   typedef struct packed {
      row_kind_t              kind;
      reg_index_type          index;
      logic [CFG_DATA_BITS-1:0] wdata;
      logic                   cmd;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   typed;
      logic [1:0]             n_typed;
      cc_msg_t                msg_a;
      cc_msg_t                msg_b;
   } stim_row_t;

   localparam cc_msg_t NO_MSG = '0;

   localparam stim_row_t DIRECTED [43] = '{
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd0, 1'b1, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd1023, 1'b1, 2'd1,
        '{7'd0, 7'd127, 5'd1, 1'b1}, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd0, 1'b1, 2'd1,
        '{7'd0, 7'd0, 5'd1, 1'b1}, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1023, 1'b1, 2'd1,
        '{7'd0, 7'd127, 5'd1, 1'b1}, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1023, 1'b1, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1021, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1019, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_KILL, 10'd5, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_CONTROL, 10'd127, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_CHANNEL, 10'd16, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd0, 1'b1, 2'd1,
        '{7'd127, 7'd0, 5'd16, 1'b1}, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1023, 1'b1, 2'd2,
        '{7'd5, 7'd127, 5'd16, 1'b0}, '{7'd127, 7'd127, 5'd16, 1'b1}},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd0, 1'b1, 2'd2,
        '{7'd127, 7'd0, 5'd16, 1'b0}, '{7'd5, 7'd0, 5'd16, 1'b1}},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd512, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_LOW, 10'd200, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_HIGH, 10'd800, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_OUT_LOW, 10'd100, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_OUT_HIGH, 10'd20, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd100, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd900, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_LOW, 10'd600, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_HIGH, 10'd600, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd5, 1'b1, 2'd1,
        '{7'd127, 7'd100, 5'd16, 1'b1}, NO_MSG},
      '{ROW_WRITE, REG_IN_LOW, 10'd900, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_HIGH, 10'd100, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd50, 1'b1, 2'd1,
        '{7'd127, 7'd100, 5'd16, 1'b1}, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b1, 10'd950, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd950, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_THRESHOLD, 10'd0, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_OUT_LOW, 10'h3FF, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_OUT_HIGH, 10'd0, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_LOW, 10'd0, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_IN_HIGH, 10'd1023, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_CHANNEL, 10'd0, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_THRESHOLD, 10'd255, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_CHANNEL, 10'h3FF, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_WRITE, REG_KILL, 10'd127, 1'b0, 10'd0, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1023, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1000, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1023, 1'b0, 2'd0, NO_MSG, NO_MSG},
      '{ROW_ITEM, REG_THRESHOLD, 10'd0, 1'b0, 10'd1000, 1'b0, 2'd0, NO_MSG, NO_MSG}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CFG_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_wdata;

   pmcs_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   pmcs_rsp_if rsp_chan ();

   pot_to_midi_cc_smoother #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfg_type     cc_cfg;
   int          smoothed;
   int          change_acc;
   int          last_value;
   cc_msg_t     emitted_now[$];
   cc_msg_t     cc_msgs_due[$];
   int unsigned sender_pct = 0;
   int unsigned receiver_pct = 0;
   int unsigned fail_count = 0;
   int unsigned stall_cycles = 0;
   bit          needs_settle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int map_to_cc(input int lvl);
      int lo, hi, x, olo, ohi, m, lo_cc, hi_cc;
      lo  = int'(cc_cfg.in_low);
      hi  = int'(cc_cfg.in_high);
      olo = int'(cc_cfg.out_low);
      ohi = int'(cc_cfg.out_high);
      x   = lvl;
      if (x < lo) begin
         x = lo;
      end else if (x > hi) begin
         x = hi;
      end
      if (hi == lo) begin
         m = olo;
      end else begin
         m = (x - lo) * (ohi - olo) / (hi - lo) + olo;
      end
      lo_cc = (olo < ohi) ? olo : ohi;
      hi_cc = (olo < ohi) ? ohi : olo;
      if (m < lo_cc) m = lo_cc;
      if (m > hi_cc) m = hi_cc;
      return m;
   endfunction

   function automatic void smooth_and_emit(input logic c, input logic [SAMPLE_BITS-1:0] s);
      int acc, mapped, thr, olo;
      bit kill_on, kill_off;
      emitted_now.delete();
      thr = int'(cc_cfg.smoothing_threshold);
      olo = int'(cc_cfg.out_low);
      if (c) begin
         smoothed = int'(s);
         mapped = map_to_cc(smoothed);
         emitted_now.push_back('{cc_cfg.control_number, mapped[CC_BITS-1:0],
                                 cc_cfg.midi_channel, 1'b1});
         last_value = mapped;
         return;
      end
      if (s == '0) begin
         acc = -thr;
      end else if (int'(s) == smoothed) begin
         acc = change_acc / 2;
      end else begin
         acc = change_acc + (int'(s) - smoothed);
      end
      if ((acc < 0 ? -acc : acc) >= thr) begin
         smoothed = int'(s);
         acc = 0;
      end
      change_acc = acc;
      mapped = map_to_cc(smoothed);
      if (mapped == last_value) return;
      kill_on  = (cc_cfg.kill_number != '0) && (last_value == olo) && (mapped > olo);
      kill_off = (cc_cfg.kill_number != '0) && (last_value >= olo) && (mapped == olo);
      if (kill_on) begin
         emitted_now.push_back('{cc_cfg.kill_number, CC_MAX, cc_cfg.midi_channel, 1'b0});
      end
      emitted_now.push_back('{cc_cfg.control_number, mapped[CC_BITS-1:0],
                              cc_cfg.midi_channel, !kill_off});
      if (kill_off) begin
         emitted_now.push_back('{cc_cfg.kill_number, CC_OFF, cc_cfg.midi_channel, 1'b1});
      end
      last_value = mapped;
   endfunction

   function automatic void check_field(input string name, input logic [CC_BITS-1:0] want,
                                       input logic [CC_BITS-1:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   task automatic write_csr(input reg_index_type idx, input logic [CFG_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_THRESHOLD: cc_cfg.smoothing_threshold = d[THRESH_BITS-1:0];
         REG_IN_LOW:    cc_cfg.in_low = d[WINDOW_BITS-1:0];
         REG_IN_HIGH:   cc_cfg.in_high = d[WINDOW_BITS-1:0];
         REG_OUT_LOW:   cc_cfg.out_low = d[CC_BITS-1:0];
         REG_OUT_HIGH:  cc_cfg.out_high = d[CC_BITS-1:0];
         REG_CONTROL:   cc_cfg.control_number = d[CC_BITS-1:0];
         REG_KILL:      cc_cfg.kill_number = d[CC_BITS-1:0];
         REG_CHANNEL:   cc_cfg.midi_channel = d[CHANNEL_BITS-1:0];
         default: ;
      endcase
   endtask

   // wait for every message and for a sample that emits nothing to finish
   task automatic drain_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (cc_msgs_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      needs_settle = 1'b0;
   endtask

   task automatic send_sample(input logic c, input logic [SAMPLE_BITS-1:0] s,
                              input logic typed, input logic [1:0] n_typed,
                              input cc_msg_t ma, input cc_msg_t mb);
      @(negedge clock);
      while ($urandom_range(99) < sender_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= c;
      req_chan.sample <= s;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      smooth_and_emit(c, s);
      if (typed) begin
         if (n_typed > 2'd0) cc_msgs_due.push_back(ma);
         if (n_typed > 2'd1) cc_msgs_due.push_back(mb);
      end else begin
         foreach (emitted_now[i]) cc_msgs_due.push_back(emitted_now[i]);
      end
      needs_settle = 1'b1;
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_pct);
      end
   end

   always @(posedge clock) begin
      cc_msg_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (cc_msgs_due.size() == 0) begin
            fail_count++;
            $error("unexpected message: controller %0d level %0d channel %0d last %0d",
                   rsp_chan.controller, rsp_chan.level, rsp_chan.channel, rsp_chan.last);
         end else begin
            want = cc_msgs_due.pop_front();
            check_field("controller", want.controller, rsp_chan.controller);
            check_field("level", want.level, rsp_chan.level);
            check_field("channel", CC_BITS'(want.channel), CC_BITS'(rsp_chan.channel));
            check_field("last", CC_BITS'(want.last), CC_BITS'(rsp_chan.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_t row;
      int        k, span, target, noise;
      int        thr_v, lo_v, hi_v, olo_v, ohi_v, ctl_v, kill_v, ch_v;
      logic      c;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= REG_THRESHOLD;
      csr_wdata       <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.cmd    <= 1'b0;
      req_chan.sample <= '0;
      cc_cfg     = '{8'd4, 10'd0, 10'd1023, 7'd0, 7'd127, 7'd0, 7'd0, 5'd1};
      smoothed   = 0;
      change_acc = 0;
      last_value = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.kind == ROW_WRITE) begin
            if (needs_settle) drain_block();
            write_csr(row.index, row.wdata);
         end else begin
            send_sample(row.cmd, row.sample, row.typed, row.n_typed, row.msg_a, row.msg_b);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         sender_pct   = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 33 : 0;
         receiver_pct = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 33 : 0;

         case ($urandom_range(3))
            0: thr_v = 0;
            1: thr_v = 1;
            2: thr_v = 255;
            default: thr_v = $urandom_range(32, 2);
         endcase
         k = $urandom_range(9);
         if (p == 0 || k == 0) begin
            lo_v = 0;
            hi_v = 1023;
         end else if (k == 1) begin
            lo_v = $urandom_range(1023);
            hi_v = lo_v;
         end else if (k == 2) begin
            lo_v = $urandom_range(1023, 512);
            hi_v = $urandom_range(511);
         end else begin
            lo_v = $urandom_range(400);
            hi_v = $urandom_range(1023, 600);
         end
         if (p == 0) begin
            olo_v = 0;
            ohi_v = 127;
         end else if (p == 1) begin
            olo_v = 127;
            ohi_v = 0;
         end else begin
            olo_v = $urandom_range(127);
            ohi_v = $urandom_range(127);
         end
         ctl_v  = (p == 0) ? 127 : $urandom_range(127);
         kill_v = (p == 0) ? 127 : (p == 1) ? 1 :
                  ($urandom_range(2) == 0) ? 0 : $urandom_range(127, 1);
         ch_v   = $urandom_range(31);
         noise  = (p % 2 == 1) ? $urandom_range(1023) : 0;

         // odd phases also drive random data bits above each narrower register's width
         write_csr(REG_THRESHOLD, {noise[9:8], thr_v[7:0]});
         write_csr(REG_IN_LOW, lo_v[9:0]);
         write_csr(REG_IN_HIGH, hi_v[9:0]);
         write_csr(REG_OUT_LOW, {noise[9:7], olo_v[6:0]});
         write_csr(REG_OUT_HIGH, {noise[9:7], ohi_v[6:0]});
         write_csr(REG_CONTROL, {noise[9:7], ctl_v[6:0]});
         write_csr(REG_KILL, {noise[9:7], kill_v[6:0]});
         write_csr(REG_CHANNEL, {noise[9:5], ch_v[4:0]});

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            k = $urandom_range(99);
            c = (k < 8);
            if (k < 8 || k >= 80) begin
               target = $urandom_range(1023);
            end else if (k < 18) begin
               target = 0;
            end else if (k < 30) begin
               target = smoothed;
            end else if (k < 36) begin
               target = 1023;
            end else begin
               // small steps around the level so the accumulator builds up
               span   = int'(cc_cfg.smoothing_threshold) / 2 + 2;
               target = smoothed + int'($urandom_range(2 * span)) - span;
               if (target < 0) target = 0;
               if (target > 1023) target = 1023;
            end
            send_sample(c, target[SAMPLE_BITS-1:0], 1'b0, 2'd0, NO_MSG, NO_MSG);
         end
      end

      drain_block();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/pmcs_pkg.sv
hdl/pmcs_channels.sv
hdl/pmcs_cfg_regs.sv
hdl/pmcs_divider.sv
hdl/pot_to_midi_cc_smoother.sv
bench/tb_top.sv
